### rtl/core/dad_pkg.sv
// Shared types, constants and helpers for the detector anchor decoder.
package dad_pkg;

  // Fixed-point format of all values (Q16.16)
  localparam int FRAC_BITS  = 16;
  localparam int WIDE_SHIFT = 2 * FRAC_BITS;

  // Anchors per frame; the anchor counter wraps after the last one
  localparam int ANCHORS_PER_FRAME = 8400;

  // Field widths
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 9;
  localparam int CLASS_W  = 8;
  localparam int ANCHOR_W = 16;
  localparam int THR_W    = 17;
  localparam int PAD_W    = 28;
  localparam int INV_W    = 25;
  localparam int BOX_W    = 16;
  localparam int CFG_W    = 28;
  localparam int CFG_IDX_W = 3;

  // Back-end arithmetic widths: 2*c - w - 2*pad fits in 35 bits signed
  localparam int EDGE_W  = 35;
  localparam int SPLIT   = 17;                  // low slice of the edge term
  localparam int HI_W    = EDGE_W - SPLIT;      // signed high slice
  localparam int INVS_W  = INV_W + 1;           // inverse scale as signed
  localparam int PPART_W = (SPLIT + 1) + INVS_W;
  localparam int PEDGE_W = EDGE_W + INVS_W;
  localparam int PSIZE_W = VALUE_W + INVS_W;

  // Queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE   = 3'd4;

  // Reset values
  localparam logic [CLASS_W-1:0] CLASS_COUNT_RST = 8'd80;
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = 17'd16384;
  localparam logic [INV_W-1:0]   INV_SCALE_RST   = INV_W'(1 << FRAC_BITS);
  localparam logic signed [VALUE_W-1:0] MINUS_ONE = -(VALUE_W'(1) << FRAC_BITS);

  // Configuration registers
  typedef struct packed {
    logic [CLASS_W-1:0]      class_count;
    logic [THR_W-1:0]        score_threshold;
    logic signed [PAD_W-1:0] pad_left;
    logic signed [PAD_W-1:0] pad_top;
    logic [INV_W-1:0]        inverse_scale;
  } cfg_t;

  // One finished anchor that passed the threshold
  typedef struct packed {
    logic signed [VALUE_W-1:0] center_x;
    logic signed [VALUE_W-1:0] center_y;
    logic signed [VALUE_W-1:0] raw_width;
    logic signed [VALUE_W-1:0] raw_height;
    logic [CLASS_W-1:0]        class_index;
    logic signed [VALUE_W-1:0] best_score;
    logic [ANCHOR_W-1:0]       anchor_number;
  } job_t;

  // Shift right rounding toward zero, then saturate to signed 16 bits
  function automatic logic signed [BOX_W-1:0] trunc_sat(input logic signed [63:0] x,
                                                         input int shift);
    logic signed [63:0] bias;
    logic signed [63:0] q;
    logic signed [BOX_W-1:0] r;
    bias = x[63] ? ((64'sd1 <<< shift) - 64'sd1) : 64'sd0;
    q = (x + bias) >>> shift;
    if (q > 64'sd32767) r = 16'sh7fff;
    else if (q < -64'sd32768) r = 16'sh8000;
    else r = q[BOX_W-1:0];
    return r;
  endfunction

endpackage

### rtl/core/dad_front.sv
// Front end: takes values, tracks anchor position, box values and best score.
module dad_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [dad_pkg::VALUE_W-1:0] value,
  input  dad_pkg::cfg_t                      cfg,
  input  logic                               queue_full,
  output logic                               push,
  output dad_pkg::job_t                      push_job
);

  logic [dad_pkg::POS_W-1:0]          position;
  logic signed [dad_pkg::VALUE_W-1:0] center_x;
  logic signed [dad_pkg::VALUE_W-1:0] center_y;
  logic signed [dad_pkg::VALUE_W-1:0] raw_width;
  logic signed [dad_pkg::VALUE_W-1:0] raw_height;
  logic signed [dad_pkg::VALUE_W-1:0] running_best;
  logic [dad_pkg::CLASS_W-1:0]        running_class;
  logic [dad_pkg::ANCHOR_W-1:0]       anchor_counter;

  logic [dad_pkg::POS_W-1:0]          last_pos;
  logic                               at_last;
  logic                               accept;
  logic                               best_upd;
  logic signed [dad_pkg::VALUE_W-1:0] best_next;
  logic [dad_pkg::CLASS_W-1:0]        class_next;
  logic signed [dad_pkg::VALUE_W-1:0] height_next;
  logic                               pass;

  // Anchor ends at position 3 + class_count
  assign last_pos = dad_pkg::POS_W'(3) + dad_pkg::POS_W'(cfg.class_count);
  assign at_last  = (position >= last_pos);

  // Only the closing value of an anchor can need a queue slot
  assign in_stall = at_last && queue_full;
  assign accept   = in_valid && !in_stall;

  // Score update, first maximum wins
  assign best_upd    = (position > dad_pkg::POS_W'(3)) && (value > running_best);
  assign best_next   = best_upd ? value : running_best;
  assign class_next  = best_upd ? dad_pkg::CLASS_W'(position - dad_pkg::POS_W'(4))
                                : running_class;
  assign height_next = (position == dad_pkg::POS_W'(3)) ? value : raw_height;

  assign pass = $signed({best_next[dad_pkg::VALUE_W-1], best_next}) >=
                $signed({{(dad_pkg::VALUE_W + 1 - dad_pkg::THR_W){1'b0}},
                         cfg.score_threshold});

  assign push = accept && at_last && pass;

  always_comb begin
    push_job.center_x      = center_x;
    push_job.center_y      = center_y;
    push_job.raw_width     = raw_width;
    push_job.raw_height    = height_next;
    push_job.class_index   = class_next;
    push_job.best_score    = best_next;
    push_job.anchor_number = anchor_counter;
  end

  // Anchor control state
  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      running_best   <= dad_pkg::MINUS_ONE;
      running_class  <= '0;
      anchor_counter <= '0;
    end else if (accept) begin
      if (at_last) begin
        position      <= '0;
        running_best  <= dad_pkg::MINUS_ONE;
        running_class <= '0;
        if (anchor_counter == dad_pkg::ANCHOR_W'(dad_pkg::ANCHORS_PER_FRAME - 1))
          anchor_counter <= '0;
        else
          anchor_counter <= anchor_counter + dad_pkg::ANCHOR_W'(1);
      end else begin
        position      <= position + dad_pkg::POS_W'(1);
        running_best  <= best_next;
        running_class <= class_next;
      end
    end
  end

  // Box value capture
  always_ff @(posedge clk) begin
    if (accept) begin
      case (position)
        dad_pkg::POS_W'(0): center_x   <= value;
        dad_pkg::POS_W'(1): center_y   <= value;
        dad_pkg::POS_W'(2): raw_width  <= value;
        dad_pkg::POS_W'(3): raw_height <= value;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/dad_queue.sv
// Small FIFO of finished anchors between the front and back ends.
module dad_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dad_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output dad_pkg::job_t pop_job
);

  dad_pkg::job_t                   slots [dad_pkg::QUEUE_DEPTH];
  logic [dad_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [dad_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [dad_pkg::QUEUE_CNT_W-1:0] count;
  logic                            do_push;
  logic                            do_pop;

  assign full      = (count == dad_pkg::QUEUE_CNT_W'(dad_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + dad_pkg::QUEUE_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + dad_pkg::QUEUE_PTR_W'(1);
      if (do_push && !do_pop)
        count <= count + dad_pkg::QUEUE_CNT_W'(1);
      else if (do_pop && !do_push)
        count <= count - dad_pkg::QUEUE_CNT_W'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

endmodule

### rtl/core/dad_back.sv
// Back end: letterbox mapping pipeline with the output register at its end.
module dad_back (
  input  logic                              clk,
  input  logic                              rst,
  input  dad_pkg::cfg_t                     cfg,
  input  logic                              job_valid,
  input  dad_pkg::job_t                     job,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dad_pkg::BOX_W-1:0]  box_left,
  output logic signed [dad_pkg::BOX_W-1:0]  box_top,
  output logic signed [dad_pkg::BOX_W-1:0]  box_width,
  output logic signed [dad_pkg::BOX_W-1:0]  box_height,
  output logic [dad_pkg::CLASS_W-1:0]       class_index,
  output logic signed [dad_pkg::VALUE_W-1:0] best_score,
  output logic [dad_pkg::ANCHOR_W-1:0]      anchor_number
);

  // Side information carried down the pipeline
  typedef struct packed {
    logic [dad_pkg::CLASS_W-1:0]        class_index;
    logic signed [dad_pkg::VALUE_W-1:0] best_score;
    logic [dad_pkg::ANCHOR_W-1:0]       anchor_number;
  } tag_t;

  logic advance;

  // Stage 1: edge terms
  logic                               s1_valid;
  tag_t                               s1_tag;
  logic signed [dad_pkg::EDGE_W-1:0]  s1_nx;
  logic signed [dad_pkg::EDGE_W-1:0]  s1_ny;
  logic signed [dad_pkg::VALUE_W-1:0] s1_w;
  logic signed [dad_pkg::VALUE_W-1:0] s1_h;

  // Stage 2: partial products
  logic                               s2_valid;
  tag_t                               s2_tag;
  logic signed [dad_pkg::PPART_W-1:0] s2_nx_lo;
  logic signed [dad_pkg::PPART_W-1:0] s2_nx_hi;
  logic signed [dad_pkg::PPART_W-1:0] s2_ny_lo;
  logic signed [dad_pkg::PPART_W-1:0] s2_ny_hi;
  logic signed [dad_pkg::PSIZE_W-1:0] s2_wp;
  logic signed [dad_pkg::PSIZE_W-1:0] s2_hp;

  // Stage 3: full products
  logic                               s3_valid;
  tag_t                               s3_tag;
  logic signed [dad_pkg::PEDGE_W-1:0] s3_xp;
  logic signed [dad_pkg::PEDGE_W-1:0] s3_yp;
  logic signed [dad_pkg::PSIZE_W-1:0] s3_wp;
  logic signed [dad_pkg::PSIZE_W-1:0] s3_hp;

  logic signed [dad_pkg::INVS_W-1:0]  inv_s;
  tag_t                               job_tag;

  assign inv_s = $signed({1'b0, cfg.inverse_scale});
  assign job_tag.class_index   = job.class_index;
  assign job_tag.best_score    = job.best_score;
  assign job_tag.anchor_number = job.anchor_number;

  // The whole pipeline moves whenever the output register can take a result
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && job_valid;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= job_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    if (advance) begin
      // 2*c - size - 2*pad
      s1_tag <= job_tag;
      s1_nx  <= (dad_pkg::EDGE_W'(job.center_x) <<< 1) - dad_pkg::EDGE_W'(job.raw_width)
                - (dad_pkg::EDGE_W'(cfg.pad_left) <<< 1);
      s1_ny  <= (dad_pkg::EDGE_W'(job.center_y) <<< 1) - dad_pkg::EDGE_W'(job.raw_height)
                - (dad_pkg::EDGE_W'(cfg.pad_top) <<< 1);
      s1_w   <= job.raw_width;
      s1_h   <= job.raw_height;

      // Edge terms split into a low unsigned and a high signed slice
      s2_tag   <= s1_tag;
      s2_nx_lo <= $signed({1'b0, s1_nx[dad_pkg::SPLIT-1:0]}) * inv_s;
      s2_nx_hi <= dad_pkg::PPART_W'($signed(s1_nx[dad_pkg::EDGE_W-1:dad_pkg::SPLIT]) * inv_s);
      s2_ny_lo <= $signed({1'b0, s1_ny[dad_pkg::SPLIT-1:0]}) * inv_s;
      s2_ny_hi <= dad_pkg::PPART_W'($signed(s1_ny[dad_pkg::EDGE_W-1:dad_pkg::SPLIT]) * inv_s);
      s2_wp    <= s1_w * inv_s;
      s2_hp    <= s1_h * inv_s;

      // Recombine the slices
      s3_tag <= s2_tag;
      s3_xp  <= (dad_pkg::PEDGE_W'(s2_nx_hi) <<< dad_pkg::SPLIT) + dad_pkg::PEDGE_W'(s2_nx_lo);
      s3_yp  <= (dad_pkg::PEDGE_W'(s2_ny_hi) <<< dad_pkg::SPLIT) + dad_pkg::PEDGE_W'(s2_ny_lo);
      s3_wp  <= s2_wp;
      s3_hp  <= s2_hp;

      // Truncate toward zero, saturate, register for output
      box_left      <= dad_pkg::trunc_sat(64'(s3_xp), dad_pkg::WIDE_SHIFT + 1);
      box_top       <= dad_pkg::trunc_sat(64'(s3_yp), dad_pkg::WIDE_SHIFT + 1);
      box_width     <= dad_pkg::trunc_sat(64'(s3_wp), dad_pkg::WIDE_SHIFT);
      box_height    <= dad_pkg::trunc_sat(64'(s3_hp), dad_pkg::WIDE_SHIFT);
      class_index   <= s3_tag.class_index;
      best_score    <= s3_tag.best_score;
      anchor_number <= s3_tag.anchor_number;
    end
  end

endmodule

### rtl/core/detector_anchor_decode.sv
// Top level: configuration registers and the front, queue and back ends.
//
// Takes one Q16.16 value per cycle: per anchor four box values (center x,
// center y, width, height) then class_count scores. The front end tracks the
// best score and, at the anchor's last score, queues the anchor if the score
// reaches the threshold. The back end maps the box to the original image in a
// four-stage pipeline (edge terms, partial products of the 35 by 26 bit edge
// multiply, recombination, truncation with saturation into the output
// register). Input rate is one value per cycle; the front stalls only on an
// anchor's last value while the two-entry queue is full, which happens only
// when the output side is stalled. Configuration is taken at any time but
// must only change while the block holds no pending anchor results.
module detector_anchor_decode (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [dad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dad_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [dad_pkg::VALUE_W-1:0]   value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dad_pkg::BOX_W-1:0]     box_left,
  output logic signed [dad_pkg::BOX_W-1:0]     box_top,
  output logic signed [dad_pkg::BOX_W-1:0]     box_width,
  output logic signed [dad_pkg::BOX_W-1:0]     box_height,
  output logic [dad_pkg::CLASS_W-1:0]          class_index,
  output logic signed [dad_pkg::VALUE_W-1:0]   best_score,
  output logic [dad_pkg::ANCHOR_W-1:0]         anchor_number
);

  dad_pkg::cfg_t cfg;
  logic          push;
  dad_pkg::job_t push_job;
  logic          queue_full;
  logic          pop;
  logic          job_valid;
  dad_pkg::job_t pop_job;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.class_count     <= dad_pkg::CLASS_COUNT_RST;
      cfg.score_threshold <= dad_pkg::THRESHOLD_RST;
      cfg.pad_left        <= '0;
      cfg.pad_top         <= '0;
      cfg.inverse_scale   <= dad_pkg::INV_SCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dad_pkg::REG_CLASS_COUNT:
          cfg.class_count <= cfg_data[dad_pkg::CLASS_W-1:0];
        dad_pkg::REG_SCORE_THRESHOLD:
          cfg.score_threshold <= cfg_data[dad_pkg::THR_W-1:0];
        dad_pkg::REG_PAD_LEFT:
          cfg.pad_left <= $signed(cfg_data[dad_pkg::PAD_W-1:0]);
        dad_pkg::REG_PAD_TOP:
          cfg.pad_top <= $signed(cfg_data[dad_pkg::PAD_W-1:0]);
        dad_pkg::REG_INVERSE_SCALE:
          cfg.inverse_scale <= cfg_data[dad_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  dad_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  dad_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (job_valid),
    .pop_job   (pop_job)
  );

  dad_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .job_valid     (job_valid),
    .job           (pop_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .box_left      (box_left),
    .box_top       (box_top),
    .box_width     (box_width),
    .box_height    (box_height),
    .class_index   (class_index),
    .best_score    (best_score),
    .anchor_number (anchor_number)
  );

endmodule

### tb/detector_anchor_decode_test.sv
// Self-checking testbench for detector_anchor_decode: directed rows, random phases, back-pressure.
module detector_anchor_decode_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;     // back end is four stages deep
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_PHASES  = 8;
  // No register lives at this index; writes to it must be dropped
  localparam logic [dad_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic signed [dad_pkg::BOX_W-1:0]   left;
    logic signed [dad_pkg::BOX_W-1:0]   top;
    logic signed [dad_pkg::BOX_W-1:0]   width;
    logic signed [dad_pkg::BOX_W-1:0]   height;
    logic [dad_pkg::CLASS_W-1:0]        cls;
    logic signed [dad_pkg::VALUE_W-1:0] score;
    logic [dad_pkg::ANCHOR_W-1:0]       anchor;
  } box_t;

  typedef enum logic {ROW_VALUE, ROW_WRITE} row_op_e;
  typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_e;

  typedef struct {
    row_op_e                       op;
    logic [dad_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                   data;
    bit                            has_box;
    box_t                          box;
  } row_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 cfg_write;
  logic [dad_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [dad_pkg::CFG_W-1:0]            cfg_data;
  logic                                 in_valid;
  logic                                 in_stall;
  logic signed [dad_pkg::VALUE_W-1:0]   value;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [dad_pkg::BOX_W-1:0]     box_left;
  logic signed [dad_pkg::BOX_W-1:0]     box_top;
  logic signed [dad_pkg::BOX_W-1:0]     box_width;
  logic signed [dad_pkg::BOX_W-1:0]     box_height;
  logic [dad_pkg::CLASS_W-1:0]          class_index;
  logic signed [dad_pkg::VALUE_W-1:0]   best_score;
  logic [dad_pkg::ANCHOR_W-1:0]         anchor_number;

  detector_anchor_decode uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .box_left(box_left), .box_top(box_top), .box_width(box_width),
    .box_height(box_height), .class_index(class_index),
    .best_score(best_score), .anchor_number(anchor_number)
  );

  always #10 clk = ~clk;

  // Mirror of the configuration registers
  int     classes_per_anchor;
  longint min_score;
  longint pad_x;
  longint pad_y;
  longint inv_scale;

  // Mirror of the decoder state
  int     slot;
  longint ctr_x, ctr_y, size_w, size_h;
  longint top_score;
  int     top_class;
  int     anchor_idx;

  box_t   expected_boxes[$];
  row_t   directed_rows[$];
  logic signed [dad_pkg::VALUE_W-1:0] last_score;

  int sender_idle_pct;
  int recv_stall_pct;
  int holdoff_asked;
  int holdoff_taken;
  int holdoff_left;
  int quiet_cycles;
  int failures;
  int values_sent;
  int boxes_checked;

  // Divide by a power of two, rounding toward zero
  function automatic longint shift_to_zero(longint x, int s);
    return (x < 0) ? -((-x) >>> s) : (x >>> s);
  endfunction

  function automatic logic signed [dad_pkg::BOX_W-1:0] clamp16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[dad_pkg::BOX_W-1:0];
  endfunction

  // Advance the decoder mirror by one value; returns 1 when a box comes out
  function automatic bit decode_value(input logic signed [dad_pkg::VALUE_W-1:0] v,
                                      output box_t b);
    longint sv;
    longint nx;
    longint ny;
    bit     hit;
    sv  = v;
    hit = 1'b0;
    b   = '0;
    case (slot)
      0: ctr_x = sv;
      1: ctr_y = sv;
      2: size_w = sv;
      3: size_h = sv;
      default: begin
        // strict compare keeps the first class on ties
        if (sv > top_score) begin
          top_score = sv;
          top_class = (slot - 4) & 8'hff;
        end
      end
    endcase
    if (slot >= 3 + classes_per_anchor) begin
      if (top_score >= min_score) begin
        nx = 2 * ctr_x - size_w - 2 * pad_x;
        ny = 2 * ctr_y - size_h - 2 * pad_y;
        b.left   = clamp16(shift_to_zero(nx * inv_scale, 2 * dad_pkg::FRAC_BITS + 1));
        b.top    = clamp16(shift_to_zero(ny * inv_scale, 2 * dad_pkg::FRAC_BITS + 1));
        b.width  = clamp16(shift_to_zero(size_w * inv_scale, 2 * dad_pkg::FRAC_BITS));
        b.height = clamp16(shift_to_zero(size_h * inv_scale, 2 * dad_pkg::FRAC_BITS));
        b.cls    = top_class[dad_pkg::CLASS_W-1:0];
        b.score  = top_score[dad_pkg::VALUE_W-1:0];
        b.anchor = anchor_idx[dad_pkg::ANCHOR_W-1:0];
        hit = 1'b1;
      end
      anchor_idx = (anchor_idx + 1 >= dad_pkg::ANCHORS_PER_FRAME) ? 0 : anchor_idx + 1;
      slot       = 0;
      top_score  = -(longint'(1) << dad_pkg::FRAC_BITS);
      top_class  = 0;
    end else begin
      slot++;
    end
    return hit;
  endfunction

  // Random value shaped by where the anchor stands
  function automatic logic signed [dad_pkg::VALUE_W-1:0] pick_value();
    int r;
    logic signed [dad_pkg::VALUE_W-1:0] v;
    r = $urandom_range(99);
    if (r < 6) v = $urandom;
    else if (r < 10) begin
      case ($urandom_range(3))
        0: v = 32'sh7fff_ffff;
        1: v = 32'sh8000_0000;
        2: v = 32'sh0;
        default: v = -32'sd1;
      endcase
    end else if (slot < 4) v = $urandom_range(0, 640 << dad_pkg::FRAC_BITS);
    else if (r < 25) v = last_score;
    else v = int'($urandom_range(0, 131072)) - 32768;
    if (slot >= 4) last_score = v;
    return v;
  endfunction

  // In-frame box values and non-negative scores: every anchor passes a zero threshold
  function automatic logic signed [dad_pkg::VALUE_W-1:0] calm_value();
    if (slot < 4) return $urandom_range(0, 640 << dad_pkg::FRAC_BITS);
    return $urandom_range(0, 1 << dad_pkg::FRAC_BITS);
  endfunction

  function automatic logic [dad_pkg::CFG_W-1:0] pick_pad();
    int r;
    r = $urandom_range(99);
    if (r < 10) return dad_pkg::CFG_W'($urandom);
    if (r < 15) return 28'h7ff_ffff;
    if (r < 20) return 28'h800_0000;
    return dad_pkg::CFG_W'($urandom_range(0, 80 << dad_pkg::FRAC_BITS));
  endfunction

  task automatic set_pacing(input pace_e mode);
    case (mode)
      PACE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER:   begin sender_idle_pct = 56; recv_stall_pct = 0;  end
      PACE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 56; end
      default:       begin sender_idle_pct = 34; recv_stall_pct = 34; end
    endcase
  endtask

  task automatic add_row(input row_op_e op, input logic [dad_pkg::CFG_IDX_W-1:0] idx,
                         input logic [31:0] data, input bit has_box, input box_t box);
    row_t row;
    row.op      = op;
    row.idx     = idx;
    row.data    = data;
    row.has_box = has_box;
    row.box     = box;
    directed_rows = {directed_rows, row};
  endtask

  // Stop offering, wait for every pending box, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the first write of a batch waits for the block to go idle
  task automatic write_reg(input logic [dad_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dad_pkg::CFG_W-1:0] d);
    if (!cfg_write) wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      dad_pkg::REG_CLASS_COUNT:     classes_per_anchor = d[dad_pkg::CLASS_W-1:0];
      dad_pkg::REG_SCORE_THRESHOLD: min_score = d[dad_pkg::THR_W-1:0];
      dad_pkg::REG_PAD_LEFT:        pad_x = $signed(d[dad_pkg::PAD_W-1:0]);
      dad_pkg::REG_PAD_TOP:         pad_y = $signed(d[dad_pkg::PAD_W-1:0]);
      dad_pkg::REG_INVERSE_SCALE:   inv_scale = d[dad_pkg::INV_W-1:0];
      default: ;
    endcase
  endtask

  // One value transaction; a typed box overrides the predicted one
  task automatic put_value(input logic signed [dad_pkg::VALUE_W-1:0] v, input bit typed,
                           input box_t tbox);
    box_t b;
    bit   hit;
    cfg_write <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    values_sent++;
    hit = decode_value(v, b);
    if (typed) expected_boxes = {expected_boxes, tbox};
    else if (hit) expected_boxes = {expected_boxes, b};
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // Output stall: random, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else if (holdoff_taken != holdoff_asked) begin
      holdoff_taken = holdoff_asked;
      holdoff_left  = HOLDOFF_CYCLES - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every box transaction with the oldest pending box
  always @(posedge clk) begin : box_checker
    box_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_boxes.size() == 0) begin
        $display("%0t: box for anchor %0d with none pending", $time, anchor_number);
        failures++;
      end else begin
        want = expected_boxes.pop_front();
        boxes_checked++;
        check_field("box_left", want.left, box_left);
        check_field("box_top", want.top, box_top);
        check_field("box_width", want.width, box_width);
        check_field("box_height", want.height, box_height);
        check_field("class_index", want.cls, class_index);
        check_field("best_score", want.score, best_score);
        check_field("anchor_number", want.anchor, anchor_number);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int   p;
    int   r;
    int   cc;
    int   items;
    box_t none;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    value     = '0;
    none      = '0;
    failures = 0; values_sent = 0; boxes_checked = 0; quiet_cycles = 0;
    holdoff_asked = 0; holdoff_taken = 0; holdoff_left = 0;
    last_score = '0;
    set_pacing(PACE_NONE);

    // Mirror starts from the reset state
    classes_per_anchor = dad_pkg::CLASS_COUNT_RST;
    min_score = dad_pkg::THRESHOLD_RST;
    pad_x = 0;
    pad_y = 0;
    inv_scale = dad_pkg::INV_SCALE_RST;
    slot = 0;
    ctr_x = 0; ctr_y = 0; size_w = 0; size_h = 0;
    top_score = -(longint'(1) << dad_pkg::FRAC_BITS);
    top_class = 0;
    anchor_idx = 0;

    // Reset settings; class count cut mid-anchor so the next score ends it.
    // Tie at 0.75 keeps class 1; box is (100-10, 50-5, 20, 10).
    add_row(ROW_VALUE, '0, 32'h0064_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0032_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0014_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h000a_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0000_2000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0000_c000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0000_c000, 0, none);
    add_row(ROW_WRITE, dad_pkg::REG_CLASS_COUNT, 32'd2, 0, none);
    add_row(ROW_VALUE, '0, 32'h0000_8000, 1,
            box_t'{16'sd90, 16'sd45, 16'sd20, 16'sd10, 8'd1, 32'sh0000_c000, 16'd0});
    // Extreme box values saturate; a score equal to the top threshold passes
    add_row(ROW_WRITE, dad_pkg::REG_SCORE_THRESHOLD, 32'h1_ffff, 0, none);
    add_row(ROW_VALUE, '0, 32'h7fff_ffff, 0, none);
    add_row(ROW_VALUE, '0, 32'h8000_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h8000_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h7fff_ffff, 0, none);
    add_row(ROW_VALUE, '0, 32'h0001_fffe, 0, none);
    add_row(ROW_VALUE, '0, 32'h0001_ffff, 1,
            box_t'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 8'd1, 32'sh0001_ffff, 16'd1});
    // No classes: anchor closes on its fourth value, no box
    add_row(ROW_WRITE, dad_pkg::REG_CLASS_COUNT, 32'd0, 0, none);
    add_row(ROW_VALUE, '0, 32'h1234_5678, 0, none);
    add_row(ROW_VALUE, '0, 32'hedcb_a987, 0, none);
    add_row(ROW_VALUE, '0, 32'h0000_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'hffff_ffff, 0, none);
    // Zero inverse scale zeroes the box whatever the pads; spare index is dropped
    add_row(ROW_WRITE, dad_pkg::REG_CLASS_COUNT, 32'd1, 0, none);
    add_row(ROW_WRITE, dad_pkg::REG_SCORE_THRESHOLD, 32'd0, 0, none);
    add_row(ROW_WRITE, dad_pkg::REG_PAD_LEFT, 32'h7ff_ffff, 0, none);
    add_row(ROW_WRITE, dad_pkg::REG_PAD_TOP, 32'h800_0000, 0, none);
    add_row(ROW_WRITE, dad_pkg::REG_INVERSE_SCALE, 32'd0, 0, none);
    add_row(ROW_WRITE, REG_SPARE, 32'hfff_ffff, 0, none);
    add_row(ROW_VALUE, '0, 32'h0001_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0001_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0001_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0001_0000, 0, none);
    add_row(ROW_VALUE, '0, 32'h0000_0000, 1,
            box_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'sh0, 16'd3});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    set_pacing(PACE_BOTH);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_WRITE)
        write_reg(directed_rows[i].idx, directed_rows[i].data[dad_pkg::CFG_W-1:0]);
      else
        put_value(directed_rows[i].data, directed_rows[i].has_box, directed_rows[i].box);
    end

    // Random phases, each with fresh settings and its own pacing
    for (p = 0; p < RANDOM_PHASES; p++) begin
      r = $urandom_range(99);
      if (p == 5) cc = 255;
      else if (r < 6) cc = 0;
      else if (r < 60) cc = $urandom_range(1, 4);
      else if (r < 90) cc = $urandom_range(5, 16);
      else cc = $urandom_range(17, 80);
      write_reg(dad_pkg::REG_CLASS_COUNT, dad_pkg::CFG_W'(cc));
      r = $urandom_range(99);
      if (r < 15) write_reg(dad_pkg::REG_SCORE_THRESHOLD, '0);
      else if (r < 25)
        write_reg(dad_pkg::REG_SCORE_THRESHOLD, dad_pkg::CFG_W'(17'h1_ffff));
      else if (r < 40)
        write_reg(dad_pkg::REG_SCORE_THRESHOLD,
                  dad_pkg::CFG_W'($urandom_range(0, 17'h1_ffff)));
      else
        write_reg(dad_pkg::REG_SCORE_THRESHOLD,
                  dad_pkg::CFG_W'($urandom_range(0, 1 << dad_pkg::FRAC_BITS)));
      write_reg(dad_pkg::REG_PAD_LEFT, pick_pad());
      write_reg(dad_pkg::REG_PAD_TOP, pick_pad());
      r = $urandom_range(99);
      if (r < 8) write_reg(dad_pkg::REG_INVERSE_SCALE, '0);
      else if (r < 14) write_reg(dad_pkg::REG_INVERSE_SCALE, dad_pkg::CFG_W'(1));
      else if (r < 20) write_reg(dad_pkg::REG_INVERSE_SCALE, dad_pkg::CFG_W'(25'h1ff_ffff));
      else if (r < 30)
        write_reg(dad_pkg::REG_INVERSE_SCALE, dad_pkg::CFG_W'($urandom & 32'h1ff_ffff));
      else
        write_reg(dad_pkg::REG_INVERSE_SCALE,
                  dad_pkg::CFG_W'($urandom_range(32'h8000, 32'h4_0000)));
      set_pacing(pace_e'(p % 4));
      items = (p == 5) ? 500 : 90;
      repeat (items) put_value(pick_value(), 1'b0, none);
    end

    // Back-pressure: output held off while every anchor yields a box
    write_reg(dad_pkg::REG_CLASS_COUNT, dad_pkg::CFG_W'(1));
    write_reg(dad_pkg::REG_SCORE_THRESHOLD, '0);
    write_reg(dad_pkg::REG_PAD_LEFT, '0);
    write_reg(dad_pkg::REG_PAD_TOP, '0);
    write_reg(dad_pkg::REG_INVERSE_SCALE, dad_pkg::CFG_W'(dad_pkg::INV_SCALE_RST));
    set_pacing(PACE_NONE);
    holdoff_asked++;
    repeat (40) put_value(calm_value(), 1'b0, none);
    // sender waits for the backlog to clear before going on
    wait_drained();
    set_pacing(PACE_BOTH);
    repeat (30) put_value(calm_value(), 1'b0, none);

    wait_drained();
    repeat (16) @(posedge clk);
    failures += expected_boxes.size();

    $display("Sent %0d values, checked %0d boxes: directed rows and %0d random setting phases,",
             values_sent, boxes_checked, RANDOM_PHASES);
    $display("with random pacing on both sides and a long output hold-off against a busy sender.");
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
